// File: src/ser_pkg.sv
package ser_pkg;

    localparam int CNT_W = 6;

    typedef enum logic [1:0] {
        CMD_DEFINE = 2'd0,
        CMD_PUSH   = 2'd1,
        CMD_READ   = 2'd2,
        CMD_RSVD   = 2'd3
    } cmd_e_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ERR     = 2'd1,
        ST_NONE    = 2'd2,
        ST_OVERRUN = 2'd3
    } status_e_t;

    typedef struct packed {
        cmd_e_t             command;
        logic [15:0]        point_index;
        logic [63:0]        push_value;
        logic [63:0]        push_time;
        logic [63:0]        reader_seq;
        logic [CNT_W-1:0]   count_limit;
    } ser_cmd_t;

    typedef struct packed {
        status_e_t          status;
        logic [63:0]        event_seq;
        logic [63:0]        event_time;
        logic [15:0]        event_point;
        logic [63:0]        event_value;
        logic [63:0]        new_reader_seq;
        logic [CNT_W-1:0]   read_total;
        logic               last;
    } ser_res_t;

    typedef struct packed {
        logic [63:0]        time_ms;
        logic [15:0]        point;
        logic [63:0]        value;
    } ser_entry_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PT,
        S_RCHK,
        S_RDEC,
        S_RADDR,
        S_STREAM,
        S_RESP
    } ser_state_t;

endpackage

// File: src/ser_if.sv
interface ser_cmd_if;
    import ser_pkg::*;

    logic     valid;
    logic     ready;
    ser_cmd_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ser_res_if;
    import ser_pkg::*;

    logic     valid;
    logic     ready;
    ser_res_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: src/sequenced_event_ring_top.sv
// channel   role    transaction
// cmd_ch    sink    one command: define point, push event or read history
// res_ch    source  one result; a read gives one per returned event, else one status result
//
// define and push: point table read on accept, result registered in S_PT once the output is free
// a read: S_RCHK, S_RDEC and S_RADDR, then S_STREAM gives one event per cycle, unless the result
// channel stalls, from the ring memory port; error, no-data and overrun answers come from S_RESP
// after reset the point table is cleared entry by entry in S_CLEAR, no command taken
// a stalled result holds its state; the next command is taken while it waits
module sequenced_event_ring_top #(
    parameter int RING_DEPTH = 256,
    parameter int POINTS     = 256,
    parameter int MAX_BURST  = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    ser_cmd_if.sink   cmd_ch,
    ser_res_if.source res_ch
);
    import ser_pkg::*;

    localparam int IDX_W  = $clog2(RING_DEPTH);
    localparam int PIDX_W = (POINTS > 1) ? $clog2(POINTS) : 1;
    localparam int DIFF_W = IDX_W + 1;
    localparam int SUM_W  = IDX_W + 2;

    ser_state_t state_reg, state_next;

    logic [63:0]       head_reg, head_next;
    logic [IDX_W-1:0]  head_slot_reg, head_slot_next;
    logic [PIDX_W-1:0] clr_reg, clr_next;
    logic [63:0]       diff_reg, diff_next;
    logic [63:0]       seq_reg, seq_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic [CNT_W-1:0]  remain_reg, remain_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [63:0]       nrs_reg, nrs_next;
    status_e_t         resp_status_reg, resp_status_next;
    logic [63:0]       resp_nrs_reg, resp_nrs_next;
    logic              out_valid_reg, out_valid_next;
    ser_res_t          out_data_reg, out_data_next;

    ser_cmd_t          cmd_reg;
    ser_cmd_t          cmd_capture;

    logic              pt_mem [POINTS];
    logic              pt_rdata_reg;
    logic              pt_we, pt_re, pt_wdata;
    logic [PIDX_W-1:0] pt_addr;

    ser_entry_t        ring_mem [RING_DEPTH];
    ser_entry_t        ring_rdata_reg;
    logic              ring_we, ring_re;
    logic [IDX_W-1:0]  ring_waddr, ring_raddr;
    ser_entry_t        ring_wdata;

    logic              accept;
    logic              out_free;
    logic              in_range;
    logic [64:0]       sub_w;
    logic              over_w;
    logic [CNT_W-1:0]  count_w;
    logic [SUM_W-1:0]  start_sum_w;
    logic [IDX_W-1:0]  start_slot_w;
    logic [IDX_W-1:0]  head_slot_inc;
    logic [IDX_W-1:0]  slot_inc;
    logic [CNT_W:0]    maxc_clamp;

    assign accept       = cmd_ch.valid && cmd_ch.ready;
    assign out_free     = !out_valid_reg || res_ch.ready;
    assign res_ch.valid = out_valid_reg;
    assign res_ch.data  = out_data_reg;

    assign in_range = {1'b0, cmd_ch.data.point_index} < 17'(POINTS);

    assign head_slot_inc = (head_slot_reg == IDX_W'(RING_DEPTH - 1)) ? '0
                           : head_slot_reg + 1'b1;
    assign slot_inc      = (slot_reg == IDX_W'(RING_DEPTH - 1)) ? '0 : slot_reg + 1'b1;

    assign sub_w  = {1'b0, head_reg} - {1'b0, cmd_reg.reader_seq};
    assign over_w = (|diff_reg[63:DIFF_W]) || (diff_reg[DIFF_W-1:0] > DIFF_W'(RING_DEPTH));
    assign count_w = ((diff_reg[63:CNT_W] == '0)
                      && (diff_reg[CNT_W-1:0] < cmd_reg.count_limit))
                     ? diff_reg[CNT_W-1:0] : cmd_reg.count_limit;
    assign start_sum_w = SUM_W'(head_slot_reg) + SUM_W'(RING_DEPTH) + SUM_W'(1)
                         - SUM_W'(diff_reg[DIFF_W-1:0]);
    assign start_slot_w = (start_sum_w >= SUM_W'(RING_DEPTH))
                          ? IDX_W'(start_sum_w - SUM_W'(RING_DEPTH)) : IDX_W'(start_sum_w);

    assign maxc_clamp = ({1'b0, cmd_ch.data.count_limit} > (CNT_W + 1)'(MAX_BURST))
                        ? (CNT_W + 1)'(MAX_BURST) : {1'b0, cmd_ch.data.count_limit};

    always_comb
    begin
        cmd_capture             = cmd_ch.data;
        cmd_capture.count_limit = maxc_clamp[CNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            head_reg        <= '0;
            head_slot_reg   <= '0;
            clr_reg         <= '0;
            diff_reg        <= '0;
            seq_reg         <= '0;
            slot_reg        <= '0;
            remain_reg      <= '0;
            total_reg       <= '0;
            nrs_reg         <= '0;
            resp_status_reg <= ST_OK;
            resp_nrs_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            head_slot_reg   <= head_slot_next;
            clr_reg         <= clr_next;
            diff_reg        <= diff_next;
            seq_reg         <= seq_next;
            slot_reg        <= slot_next;
            remain_reg      <= remain_next;
            total_reg       <= total_next;
            nrs_reg         <= nrs_next;
            resp_status_reg <= resp_status_next;
            resp_nrs_reg    <= resp_nrs_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (accept)
        begin
            cmd_reg <= cmd_capture;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pt_we)
        begin
            pt_mem[pt_addr] <= pt_wdata;
        end
        if (pt_re)
        begin
            pt_rdata_reg <= pt_mem[pt_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[ring_waddr] <= ring_wdata;
        end
        if (ring_re)
        begin
            ring_rdata_reg <= ring_mem[ring_raddr];
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        head_slot_next   = head_slot_reg;
        clr_next         = clr_reg;
        diff_next        = diff_reg;
        seq_next         = seq_reg;
        slot_next        = slot_reg;
        remain_next      = remain_reg;
        total_next       = total_reg;
        nrs_next         = nrs_reg;
        resp_status_next = resp_status_reg;
        resp_nrs_next    = resp_nrs_reg;
        out_valid_next   = out_valid_reg && !res_ch.ready;
        out_data_next    = out_data_reg;
        cmd_ch.ready     = 1'b0;
        pt_we            = 1'b0;
        pt_re            = 1'b0;
        pt_wdata         = 1'b0;
        pt_addr          = cmd_ch.data.point_index[PIDX_W-1:0];
        ring_we          = 1'b0;
        ring_re          = 1'b0;
        ring_waddr       = head_slot_inc;
        ring_raddr       = slot_reg;
        ring_wdata       = '{time_ms: cmd_reg.push_time,
                             point:   cmd_reg.point_index,
                             value:   cmd_reg.push_value};

        case (state_reg)
            S_CLEAR:
            begin
                pt_we   = 1'b1;
                pt_addr = clr_reg;
                if (clr_reg == PIDX_W'(POINTS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                cmd_ch.ready = 1'b1;
                if (cmd_ch.valid)
                begin
                    resp_status_next = ST_ERR;
                    resp_nrs_next    = '0;
                    case (cmd_ch.data.command)
                        CMD_DEFINE, CMD_PUSH:
                        begin
                            if (in_range)
                            begin
                                pt_re      = 1'b1;
                                state_next = S_PT;
                            end
                            else
                            begin
                                state_next = S_RESP;
                            end
                        end
                        CMD_READ:
                        begin
                            if (cmd_ch.data.count_limit == '0)
                            begin
                                resp_nrs_next = cmd_ch.data.reader_seq;
                                state_next    = S_RESP;
                            end
                            else
                            begin
                                state_next = S_RCHK;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            S_PT:
            begin
                pt_addr = cmd_reg.point_index[PIDX_W-1:0];
                if (out_free)
                begin
                    out_valid_next       = 1'b1;
                    out_data_next        = '0;
                    out_data_next.last   = 1'b1;
                    out_data_next.status = ST_ERR;
                    if (cmd_reg.command == CMD_DEFINE)
                    begin
                        if (!pt_rdata_reg)
                        begin
                            pt_we                = 1'b1;
                            pt_wdata             = 1'b1;
                            out_data_next.status = ST_OK;
                        end
                    end
                    else if (pt_rdata_reg)
                    begin
                        ring_we                   = 1'b1;
                        head_next                 = head_reg + 64'd1;
                        head_slot_next            = head_slot_inc;
                        out_data_next.status      = ST_OK;
                        out_data_next.event_seq   = head_reg + 64'd1;
                        out_data_next.event_time  = cmd_reg.push_time;
                        out_data_next.event_point = cmd_reg.point_index;
                        out_data_next.event_value = cmd_reg.push_value;
                    end
                    state_next = S_IDLE;
                end
            end

            S_RCHK:
            begin
                if (sub_w[64] || (sub_w[63:0] == '0))
                begin
                    resp_status_next = ST_NONE;
                    resp_nrs_next    = cmd_reg.reader_seq;
                    state_next       = S_RESP;
                end
                else
                begin
                    diff_next  = sub_w[63:0];
                    state_next = S_RDEC;
                end
            end

            S_RDEC:
            begin
                if (over_w)
                begin
                    resp_status_next = ST_OVERRUN;
                    resp_nrs_next    = head_reg;
                    state_next       = S_RESP;
                end
                else
                begin
                    remain_next = count_w;
                    total_next  = count_w;
                    slot_next   = start_slot_w;
                    seq_next    = cmd_reg.reader_seq + 64'd1;
                    state_next  = S_RADDR;
                end
            end

            S_RADDR:
            begin
                nrs_next   = cmd_reg.reader_seq + 64'(total_reg);
                ring_re    = 1'b1;
                slot_next  = slot_inc;
                state_next = S_STREAM;
            end

            S_STREAM:
            begin
                if (out_free)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next.status         = ST_OK;
                    out_data_next.event_seq      = seq_reg;
                    out_data_next.event_time     = ring_rdata_reg.time_ms;
                    out_data_next.event_point    = ring_rdata_reg.point;
                    out_data_next.event_value    = ring_rdata_reg.value;
                    out_data_next.new_reader_seq = nrs_reg;
                    out_data_next.read_total     = total_reg;
                    out_data_next.last           = (remain_reg == CNT_W'(1));
                    seq_next                     = seq_reg + 64'd1;
                    remain_next                  = remain_reg - 1'b1;
                    if (remain_reg == CNT_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ring_re   = 1'b1;
                        slot_next = slot_inc;
                    end
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next                = '0;
                    out_data_next.status         = resp_status_reg;
                    out_data_next.new_reader_seq = resp_nrs_reg;
                    out_data_next.last           = 1'b1;
                    state_next                   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
